/* design/rcpd_pkg.sv */
// Package: types, constants and helpers of the RC pulse decoder.
package rcpd_pkg;

	localparam int unsigned W_US    = 12;
	localparam int unsigned W_TMO   = 20;
	localparam int unsigned W_DB    = 9;
	localparam int unsigned AGE_W   = 21;
	localparam int unsigned NORM_W  = 16;
	localparam int unsigned WNORM_W = 15;
	localparam int unsigned NUM_W   = 14;
	localparam int unsigned QUO_W   = 16;
	localparam logic [15:0] Q_ONE   = 16'd32767;
	localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
	localparam int unsigned CFG_AW  = 5;

	localparam logic [2:0] REG_VALID_MIN = 3'd0;
	localparam logic [2:0] REG_VALID_MAX = 3'd1;
	localparam logic [2:0] REG_TIMEOUT   = 3'd2;
	localparam logic [2:0] REG_CENTER    = 3'd3;
	localparam logic [2:0] REG_SPAN_MIN  = 3'd4;
	localparam logic [2:0] REG_SPAN_MAX  = 3'd5;
	localparam logic [2:0] REG_DEADBAND  = 3'd6;

	typedef struct packed {
		logic [W_US-1:0]  valid_min_us;
		logic [W_US-1:0]  valid_max_us;
		logic [W_TMO-1:0] timeout_us;
		logic [W_US-1:0]  center_us;
		logic [W_US-1:0]  span_min_us;
		logic [W_US-1:0]  span_max_us;
		logic [W_DB-1:0]  deadband_us;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic [1:0] sel;
		logic       start;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage

/* design/rcpd_if.sv */
// Interfaces: input and result channels of the RC pulse decoder.
interface rcpd_in_if;
	logic valid;
	logic ready;
	logic throttle_level;
	logic steering_level;
	logic water_level_in;
	modport source (output valid, throttle_level, steering_level, water_level_in, input ready);
	modport sink (input valid, throttle_level, steering_level, water_level_in, output ready);
endinterface

interface rcpd_out_if;
	logic valid;
	logic ready;
	logic [11:0] throttle_width;
	logic [11:0] steering_width;
	logic [11:0] water_width;
	logic throttle_ok;
	logic steering_ok;
	logic water_ok;
	logic drive_ok;
	logic signed [15:0] throttle_norm;
	logic signed [15:0] steering_norm;
	logic [14:0] water_norm;
	modport source (output valid, throttle_width, steering_width, water_width, throttle_ok,
		steering_ok, water_ok, drive_ok, throttle_norm, steering_norm, water_norm,
		input ready);
	modport sink (input valid, throttle_width, steering_width, water_width, throttle_ok,
		steering_ok, water_ok, drive_ok, throttle_norm, steering_norm, water_norm,
		output ready);
endinterface

/* design/rc_pulse_decoder_unit.sv */
// Top level of the RC pulse decoder.
//  channel   dir  handshake      payload
//  in        in   valid/ready    three line levels, one beat per tick
//  out       out  valid/ready    widths, ok flags, normalized values
//  apb       in   psel/penable   seven configuration registers
// Each beat runs alone: accept, then per channel a setup state,
// 31 divide steps, a done state and an advance state on one shared divider.
// Reset arst_n acts at once on counters, control state and configuration; result registers are not reset.
// A result beat is held until taken; no input beat is taken meanwhile.
module rc_pulse_decoder_unit
	import rcpd_pkg::*;
#(
	parameter int unsigned CHANNELS   = 3,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	rcpd_in_if.sink           in_ch,
	rcpd_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	logic [W_US-1:0] wid [3];
	logic [2:0] ok;

	rcpd_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);

	rcpd_ctrl u_ctrl (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts, .cmd);

	rcpd_dp #(.CHANNELS(CHANNELS), .COUNT_BITS(COUNT_BITS)) u_dp (.clk, .arst_n, .cfg,
		.cmd, .sts,
		.lvl_in({in_ch.water_level_in, in_ch.steering_level, in_ch.throttle_level}),
		.width_o(wid), .ok_o(ok), .tn_o(out_ch.throttle_norm),
		.sn_o(out_ch.steering_norm), .wn_o(out_ch.water_norm));

	assign out_ch.throttle_width = wid[0];
	assign out_ch.steering_width = wid[1];
	assign out_ch.water_width    = wid[2];
	assign out_ch.throttle_ok    = ok[0];
	assign out_ch.steering_ok    = ok[1];
	assign out_ch.water_ok       = ok[2];
	assign out_ch.drive_ok       = ok[0] && ok[1];
endmodule

/* design/rcpd_regs.sv */
// Configuration register file behind the APB-style port.
module rcpd_regs
	import rcpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);
	cfg_t cfg_q;
	logic wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[CFG_AW-1:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.valid_min_us <= 12'd800;
			cfg_q.valid_max_us <= 12'd2200;
			cfg_q.timeout_us   <= 20'd100000;
			cfg_q.center_us    <= 12'd1500;
			cfg_q.span_min_us  <= 12'd1000;
			cfg_q.span_max_us  <= 12'd2000;
			cfg_q.deadband_us  <= 9'd25;
		end else if (wr && paddr[1:0] == 2'b00) begin
			case (idx)
				REG_VALID_MIN: cfg_q.valid_min_us <= pwdata[11:0];
				REG_VALID_MAX: cfg_q.valid_max_us <= pwdata[11:0];
				REG_TIMEOUT:   cfg_q.timeout_us   <= pwdata[19:0];
				REG_CENTER:    cfg_q.center_us    <= pwdata[11:0];
				REG_SPAN_MIN:  cfg_q.span_min_us  <= pwdata[11:0];
				REG_SPAN_MAX:  cfg_q.span_max_us  <= pwdata[11:0];
				REG_DEADBAND:  cfg_q.deadband_us  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_VALID_MIN: prdata = {20'd0, cfg_q.valid_min_us};
			REG_VALID_MAX: prdata = {20'd0, cfg_q.valid_max_us};
			REG_TIMEOUT:   prdata = {12'd0, cfg_q.timeout_us};
			REG_CENTER:    prdata = {20'd0, cfg_q.center_us};
			REG_SPAN_MIN:  prdata = {20'd0, cfg_q.span_min_us};
			REG_SPAN_MAX:  prdata = {20'd0, cfg_q.span_max_us};
			REG_DEADBAND:  prdata = {23'd0, cfg_q.deadband_us};
			default:       prdata = '0;
		endcase
		if (paddr[1:0] != 2'b00) prdata = '0;
	end
endmodule

/* design/rcpd_ctrl.sv */
// Controller: sequences capture, three divisions and result hand-off.
module rcpd_ctrl
	import rcpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_START = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_NEXT  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] sel_q, sel_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		cmd = '0;
		cmd.sel = sel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					sel_d = 2'd0;
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.finish = 1'b1;
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (sel_q == 2'd2) begin
					state_d = ST_OUT;
				end else begin
					sel_d = sel_q + 2'd1;
					state_d = ST_START;
				end
			end
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= '0;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
		end
	end

	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state not one-hot");
	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == ST_DIV) else $error("start did not enter divide");
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q != 2'd3) else $error("channel select out of range");
endmodule

/* design/rcpd_dp.sv */
// Datapath: edge counters, clamps, flags and a shared restoring divider.
module rcpd_dp
	import rcpd_pkg::*;
#(
	parameter int unsigned CHANNELS   = 3,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [2:0]  lvl_in,
	output logic [W_US-1:0] width_o [3],
	output logic [2:0]  ok_o,
	output logic signed [NORM_W-1:0] tn_o,
	output logic signed [NORM_W-1:0] sn_o,
	output logic [WNORM_W-1:0] wn_o
);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [CHANNELS-1:0]   prev_q;
	logic [COUNT_BITS-1:0] high_q [CHANNELS];
	logic [COUNT_BITS-1:0] pw_q   [CHANNELS];
	logic [AGE_W-1:0]      age_q  [CHANNELS];

	logic [W_US-1:0] wid_q [3];
	logic [2:0] ok_q;
	logic signed [NORM_W-1:0] nrm_q [3];

	// per-channel counters, updated when a beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				prev_q[c] <= 1'b0;
				high_q[c] <= '0;
				pw_q[c]   <= COUNT_BITS'(1500);
				age_q[c]  <= '0;
			end
		end else if (cmd.capture) begin
			for (int c = 0; c < CHANNELS; c++) begin
				logic l;
				l = (c < 3) ? lvl_in[c] : 1'b0;
				if (l && !prev_q[c]) high_q[c] <= COUNT_BITS'(1);
				else if (l && high_q[c] != CNT_MAX) high_q[c] <= high_q[c] + 1'b1;
				if (!l && prev_q[c]) begin
					pw_q[c] <= high_q[c];
					age_q[c] <= '0;
				end else if (age_q[c] != AGE_MAX) begin
					age_q[c] <= age_q[c] + 1'b1;
				end
				prev_q[c] <= l;
			end
		end
	end

	// clamp and valid flags from updated state, registered in the first start state after capture
	always_ff @(posedge clk) begin
		if (cmd.start && cmd.sel == 2'd0) begin
			for (int c = 0; c < 3; c++) begin
				if (c < CHANNELS) begin
					logic [COUNT_BITS-1:0] w;
					logic [W_US-1:0] cw;
					w = pw_q[c];
					if (w < COUNT_BITS'(cfg.valid_min_us)) cw = cfg.valid_min_us;
					else if (w > COUNT_BITS'(cfg.valid_max_us)) cw = cfg.valid_max_us;
					else cw = w[W_US-1:0];
					wid_q[c] <= cw;
					ok_q[c] <= (age_q[c] <= AGE_W'(cfg.timeout_us)) &&
						(cw >= cfg.valid_min_us) && (cw <= cfg.valid_max_us);
				end else begin
					wid_q[c] <= '0;
					ok_q[c] <= 1'b0;
				end
			end
		end
	end

	// operand setup for the selected channel; clamped width taken combinationally
	logic [W_US-1:0] cur_w;
	logic [COUNT_BITS-1:0] pw_sel;
	always_comb begin
		pw_sel = '0;
		for (int c = 0; c < CHANNELS; c++)
			if (c < 3 && 2'(c) == cmd.sel) pw_sel = pw_q[c];
		if (pw_sel < COUNT_BITS'(cfg.valid_min_us)) cur_w = cfg.valid_min_us;
		else if (pw_sel > COUNT_BITS'(cfg.valid_max_us)) cur_w = cfg.valid_max_us;
		else cur_w = pw_sel[W_US-1:0];
	end

	logic signed [NUM_W-1:0] num, den, delta, dbs;
	logic signed [NUM_W-1:0] mag;
	logic zero_out, sel_valid;
	always_comb begin
		delta = NUM_W'($signed({1'b0, cur_w})) - NUM_W'($signed({1'b0, cfg.center_us}));
		dbs = NUM_W'($signed({1'b0, cfg.deadband_us}));
		mag = delta[NUM_W-1] ? -delta : delta;
		sel_valid = (32'(cmd.sel) < CHANNELS);
		zero_out = !sel_valid;
		if (cmd.sel == 2'd2) begin
			num = NUM_W'($signed({1'b0, cur_w})) - NUM_W'($signed({1'b0, cfg.span_min_us}));
			den = NUM_W'($signed({1'b0, cfg.span_max_us}))
				- NUM_W'($signed({1'b0, cfg.span_min_us}));
		end else begin
			if (mag <= dbs) zero_out = 1'b1;
			if (!delta[NUM_W-1]) begin
				num = delta - dbs;
				den = NUM_W'($signed({1'b0, cfg.span_max_us}))
					- NUM_W'($signed({1'b0, cfg.center_us})) - dbs;
			end else begin
				num = delta + dbs;
				den = NUM_W'($signed({1'b0, cfg.center_us}))
					- NUM_W'($signed({1'b0, cfg.span_min_us})) - dbs;
			end
		end
	end

	// restoring divider: (an*2*32767 + ad) / (2*ad), one bit a cycle
	localparam int unsigned DVD_W = NUM_W + 17;
	localparam int unsigned DEN_W = NUM_W + 1;
	logic [DVD_W-1:0] dvd_q;
	logic [DEN_W-1:0] dvs_q;
	logic [DEN_W:0]   rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [4:0] cnt_q;
	logic neg_q, zden_q, zero_q, sgn_q, nzn_q, busy_q, done_q;
	logic [DEN_W:0] rem_sh;
	logic [DEN_W-1:0] an, ad;

	assign an = DEN_W'(num[NUM_W-1] ? -num : num);
	assign ad = DEN_W'(den[NUM_W-1] ? -den : den);
	assign rem_sh = {rem_q[DEN_W-1:0], dvd_q[DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && cnt_q == 5'd1;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q  <= DVD_W'(an) * DVD_W'(2 * 32767) + DVD_W'(ad);
			dvs_q  <= ad << 1;
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= num[NUM_W-1] ^ den[NUM_W-1];
			zden_q <= (den == '0);
			sgn_q  <= num[NUM_W-1];
			nzn_q  <= (num != '0);
			zero_q <= zero_out;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= rem_sh - {1'b0, dvs_q};
				quo_q <= (quo_q >= Q_ONE) ? Q_ONE : {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= (quo_q >= Q_ONE) ? Q_ONE : {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign sts.div_done = done_q;

	// saturate and store the result
	logic signed [NORM_W-1:0] res;
	logic [QUO_W-1:0] qs;
	always_comb begin
		qs = (quo_q > Q_ONE) ? Q_ONE : quo_q;
		if (zero_q) res = '0;
		else if (zden_q) res = !nzn_q ? '0 : (sgn_q ? -$signed(Q_ONE) : $signed(Q_ONE));
		else res = neg_q ? -$signed(qs) : $signed(qs);
		if (cmd.sel == 2'd2 && res < 0) res = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) nrm_q[cmd.sel] <= res;
	end

	assign width_o = wid_q;
	assign ok_o = ok_q;
	assign tn_o = nrm_q[0];
	assign sn_o = nrm_q[1];
	assign wn_o = nrm_q[2][WNORM_W-1:0];

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> !busy_q) else $error("done while still dividing");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q) else $error("divider restarted while busy");
	a_quo_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (res <= $signed(Q_ONE))) else $error("result above one");
endmodule

/* tb/tb_rc_pulse_decoder_unit.sv */
// Testbench: RC pulse decoder unit, checked beat by beat against an in-bench predictor.
`timescale 1ns / 100ps
module tb_rc_pulse_decoder_unit;
	import rcpd_pkg::*;

	typedef struct packed {
		logic [11:0] thr_w;
		logic [11:0] str_w;
		logic [11:0] wat_w;
		logic thr_ok;
		logic str_ok;
		logic wat_ok;
		logic drv_ok;
		logic [15:0] thr_n;
		logic [15:0] str_n;
		logic [14:0] wat_n;
	} decode_t;

	typedef struct {
		logic [2:0] lv;
		bit has_exp;
		decode_t exp;
	} stim_row_t;

	localparam int N_RANDOM = 1250;
	localparam int WDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	rcpd_in_if in_if();
	rcpd_out_if out_if();

	rc_pulse_decoder_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_if), .out_ch(out_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// decoder model state and settings
	logic [11:0] m_vmin, m_vmax, m_center, m_smin, m_smax;
	logic [19:0] m_tmo;
	logic [8:0] m_db;
	logic m_prev[3];
	logic [15:0] m_high[3];
	logic [15:0] m_width[3];
	logic [20:0] m_age[3];

	decode_t pending_decodes[$];
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int idle_cnt = 0;
	int cfg_sets = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	function automatic int q15_ratio(longint num, longint den, longint lo);
		longint an, ad, q;
		if (den == 0)
			return (num > 0) ? 32767 : (num < 0) ? int'(lo) : 0;
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = (an * 2 * 32767 + ad) / (2 * ad);
		if ((num < 0) != (den < 0)) q = -q;
		if (q > 32767) q = 32767;
		if (q < lo) q = lo;
		return int'(q);
	endfunction

	function automatic int centered_q15(logic [11:0] w);
		longint delta, db, mag;
		delta = longint'(w) - longint'(m_center);
		db = longint'(m_db);
		mag = delta < 0 ? -delta : delta;
		if (mag <= db) return 0;
		if (delta > 0)
			return q15_ratio(delta - db, longint'(m_smax) - longint'(m_center) - db, -32767);
		return q15_ratio(delta + db, longint'(m_center) - longint'(m_smin) - db, -32767);
	endfunction

	function automatic decode_t decode_tick(logic [2:0] lv);
		decode_t r;
		logic [11:0] w[3];
		logic ok[3];
		int tn, sn, wn;
		for (int c = 0; c < 3; c++) begin
			if (lv[c] && !m_prev[c]) m_high[c] = 16'd1;
			else if (lv[c] && m_high[c] != 16'hFFFF) m_high[c] = m_high[c] + 16'd1;
			if (!lv[c] && m_prev[c]) begin
				m_width[c] = m_high[c];
				m_age[c] = '0;
			end else if (m_age[c] != AGE_MAX) begin
				m_age[c] = m_age[c] + 21'd1;
			end
			m_prev[c] = lv[c];
			if (m_width[c] < m_vmin) w[c] = m_vmin;
			else if (m_width[c] > m_vmax) w[c] = m_vmax;
			else w[c] = m_width[c][11:0];
			ok[c] = (m_age[c] <= m_tmo) && (w[c] >= m_vmin) && (w[c] <= m_vmax);
		end
		tn = centered_q15(w[0]);
		sn = centered_q15(w[1]);
		wn = q15_ratio(longint'(w[2]) - longint'(m_smin),
			longint'(m_smax) - longint'(m_smin), 0);
		r.thr_w = w[0];
		r.str_w = w[1];
		r.wat_w = w[2];
		r.thr_ok = ok[0];
		r.str_ok = ok[1];
		r.wat_ok = ok[2];
		r.drv_ok = ok[0] & ok[1];
		r.thr_n = tn[15:0];
		r.str_n = sn[15:0];
		r.wat_n = wn[14:0];
		return r;
	endfunction

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_VALID_MIN: m_vmin = val[11:0];
			REG_VALID_MAX: m_vmax = val[11:0];
			REG_TIMEOUT:   m_tmo = val[19:0];
			REG_CENTER:    m_center = val[11:0];
			REG_SPAN_MIN:  m_smin = val[11:0];
			REG_SPAN_MAX:  m_smax = val[11:0];
			REG_DEADBAND:  m_db = val[8:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(logic [11:0] vmin, logic [11:0] vmax, logic [19:0] tmo,
		logic [11:0] ctr, logic [11:0] smin, logic [11:0] smax, logic [8:0] db);
		in_if.valid <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		apb_write(REG_VALID_MIN, {20'd0, vmin});
		apb_write(REG_VALID_MAX, {20'd0, vmax});
		apb_write(REG_TIMEOUT, {12'd0, tmo});
		apb_write(REG_CENTER, {20'd0, ctr});
		apb_write(REG_SPAN_MIN, {20'd0, smin});
		apb_write(REG_SPAN_MAX, {20'd0, smax});
		apb_write(REG_DEADBAND, {23'd0, db});
		cfg_sets++;
	endtask

	// hold valid across back-to-back beats; drop it only on an idle cycle
	task automatic send_tick(logic [2:0] lv, bit has_exp, decode_t exp);
		decode_t pred;
		while (!calm && $urandom_range(99) < 20) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.throttle_level <= lv[0];
		in_if.steering_level <= lv[1];
		in_if.water_level_in <= lv[2];
		do @(posedge clk); while (!in_if.ready);
		pred = decode_tick(lv);
		pending_decodes.push_back(has_exp ? exp : pred);
		beats_in++;
	endtask

	// per-line pulse trains with random high and low lengths
	int hi_left[3];
	int lo_left[3];

	function automatic logic [2:0] pulse_levels();
		logic [2:0] lv;
		for (int c = 0; c < 3; c++) begin
			if (hi_left[c] > 0) begin
				hi_left[c]--;
				lv[c] = 1'b1;
			end else if (lo_left[c] > 0) begin
				lo_left[c]--;
				lv[c] = 1'b0;
			end else begin
				hi_left[c] = $urandom_range(30);
				lo_left[c] = $urandom_range(40, 1);
				lv[c] = 1'b0;
			end
		end
		return lv;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= !hold_req && (calm || $urandom_range(99) >= 20);
		end
	end

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch expected %0h actual %0h", $time, name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		decode_t e;
		if (arst_n && out_if.valid && out_if.ready) begin
			beats_out++;
			if (pending_decodes.size() == 0) begin
				$display("%0t: unexpected result beat", $time);
				errors++;
			end else begin
				e = pending_decodes.pop_front();
				check_field("throttle_width", e.thr_w, out_if.throttle_width);
				check_field("steering_width", e.str_w, out_if.steering_width);
				check_field("water_width", e.wat_w, out_if.water_width);
				check_field("throttle_ok", e.thr_ok, out_if.throttle_ok);
				check_field("steering_ok", e.str_ok, out_if.steering_ok);
				check_field("water_ok", e.wat_ok, out_if.water_ok);
				check_field("drive_ok", e.drv_ok, out_if.drive_ok);
				check_field("throttle_norm", e.thr_n, $unsigned(out_if.throttle_norm));
				check_field("steering_norm", e.str_n, $unsigned(out_if.steering_norm));
				check_field("water_norm", e.wat_n, out_if.water_norm);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
			|| (psel && penable))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", idle_cnt);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		while (beats_in < 300) @(posedge clk);
		hold_req = 1'b1;
		for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
		hold_req = 1'b0;
	end

	stim_row_t dir_rows[$];
	decode_t boot_exp, floor_exp, no_exp;

	initial begin
		logic [2:0] lv;
		logic [11:0] ctr;
		in_if.valid = 1'b0;
		in_if.throttle_level = 1'b0;
		in_if.steering_level = 1'b0;
		in_if.water_level_in = 1'b0;
		m_vmin = 12'd800;
		m_vmax = 12'd2200;
		m_tmo = 20'd100000;
		m_center = 12'd1500;
		m_smin = 12'd1000;
		m_smax = 12'd2000;
		m_db = 9'd25;
		for (int c = 0; c < 3; c++) begin
			m_prev[c] = 1'b0;
			m_high[c] = '0;
			m_width[c] = 16'd1500;
			m_age[c] = '0;
			hi_left[c] = 0;
			lo_left[c] = 0;
		end
		no_exp = '0;
		boot_exp = '{12'd1500, 12'd1500, 12'd1500, 1'b1, 1'b1, 1'b1, 1'b1,
			16'd0, 16'd0, 15'd16384};
		floor_exp = '{12'd800, 12'd800, 12'd800, 1'b1, 1'b1, 1'b1, 1'b1,
			16'h8001, 16'h8001, 15'd0};
		dir_rows.push_back('{3'b000, 1'b1, boot_exp});
		dir_rows.push_back('{3'b111, 1'b0, no_exp});
		dir_rows.push_back('{3'b111, 1'b0, no_exp});
		dir_rows.push_back('{3'b000, 1'b1, floor_exp});
		dir_rows.push_back('{3'b001, 1'b0, no_exp});
		dir_rows.push_back('{3'b010, 1'b0, no_exp});
		dir_rows.push_back('{3'b100, 1'b0, no_exp});
		dir_rows.push_back('{3'b101, 1'b0, no_exp});
		dir_rows.push_back('{3'b011, 1'b0, no_exp});
		dir_rows.push_back('{3'b110, 1'b0, no_exp});
		dir_rows.push_back('{3'b000, 1'b0, no_exp});
		dir_rows.push_back('{3'b111, 1'b0, no_exp});
		dir_rows.push_back('{3'b000, 1'b0, no_exp});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_tick(dir_rows[i].lv, dir_rows[i].has_exp, dir_rows[i].exp);

		// short widths against a small window: clamps, deadband, saturation
		load_settings(12'd3, 12'd20, 20'd15, 12'd10, 12'd4, 12'd18, 9'd2);
		for (int k = 0; k < 10; k++) begin
			lv = (k % 5 < 3) ? 3'b111 : 3'b000;
			send_tick(lv, 1'b0, no_exp);
		end
		// zero denominators and a timeout of zero
		load_settings(12'd0, 12'd4095, 20'd0, 12'd5, 12'd5, 12'd5, 9'd0);
		for (int k = 0; k < 6; k++) send_tick(k[0] ? 3'b111 : 3'b000, 1'b0, no_exp);

		for (int ph = 0; ph < 10 && beats_in < N_RANDOM; ph++) begin
			case (ph)
				0: load_settings(12'd0, 12'd0, 20'd0, 12'd0, 12'd0, 12'd0, 9'd0);
				1: load_settings(12'd4095, 12'd4095, 20'hFFFFF, 12'd4095, 12'd4095,
					12'd4095, 9'd511);
				2: load_settings(12'd25, 12'd6, 20'd30, 12'd12, 12'd2, 12'd28, 9'd3);
				3: load_settings(12'd0, 12'd40, 20'd50, 12'd15, 12'd20, 12'd8, 9'd511);
				default: begin
					ctr = 12'($urandom_range(25, 5));
					load_settings(12'($urandom_range(8)), 12'($urandom_range(40, 10)),
						20'($urandom_range(60)), ctr, 12'($urandom_range(ctr)),
						12'($urandom_range(45, ctr)), 9'($urandom_range(6)));
				end
			endcase
			for (int k = 0; k < 150 && beats_in < N_RANDOM; k++) begin
				calm = (beats_in >= 700 && beats_in < 900);
				lv = pulse_levels();
				if ($urandom_range(99) < 10) lv = 3'($urandom_range(7));
				send_tick(lv, 1'b0, no_exp);
			end
		end
		calm = 1'b0;
		in_if.valid <= 1'b0;

		while (pending_decodes.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d ticks and %0d results over %0d register settings,",
			beats_in, beats_out, cfg_sets + 1);
		$display("including clamps, deadband, zero spans, inverted window and long back-pressure");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
